// ===== hdl/lir_pkg.sv =====
// ============================================================================
// lir_pkg
// Shared widths, constants and the job record passed from the front end
// through the job queue to the interpolation engine.
// ============================================================================
`default_nettype none

package lir_pkg;

   // Sample and position formats
   localparam int SAMPLE_BITS = 24;
   localparam int FRAC_BITS   = 24;
   localparam int MAX_RUN     = 64;
   localparam int STEP_BITS   = 32;

   // Position holds up to one full step above zero, plus a sign
   localparam int POS_BITS  = STEP_BITS + 1;
   localparam int DIFF_BITS = SAMPLE_BITS + 1;
   localparam int PROD_BITS = FRAC_BITS + 1 + DIFF_BITS;
   localparam int RUN_BITS  = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;

   // Job queue sizing
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // 1.0 in position units, and the smallest step that bounds a run
   localparam longint POS_ONE  = longint'(1) << FRAC_BITS;
   localparam longint STEP_MIN = (POS_ONE + MAX_RUN - 1) / MAX_RUN;

   localparam logic [STEP_BITS-1:0] STEP_RESET    = STEP_BITS'(POS_ONE);
   localparam logic [STEP_BITS-1:0] STEP_MIN_CODE = STEP_BITS'(STEP_MIN);
   localparam logic signed [POS_BITS:0] POS_ONE_EXT = (POS_BITS + 1)'(POS_ONE);

   // One source sample's worth of work for the engine
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] prev;
      logic signed [DIFF_BITS-1:0]   diff;
      logic [STEP_BITS-1:0]          step;
   } job_type;

endpackage

`default_nettype wire

// ===== hdl/linear_interp_resampler.sv =====
// ============================================================================
// linear_interp_resampler
// Linear-interpolation sample rate converter with a programmable Q8.24 step.
// ============================================================================
// Each accepted source sample produces zero or more interpolated samples, up
// to 64, and the final one of each run carries rsp_last_of_run. The engine
// delivers one result per clock while a run is in progress and the output
// side is not stalled, and it takes the next job only after it retires the
// current one; results pass through a multiply stage and an output register.
// A two-entry job queue sits between the input side and the engine, so
// req_ready stays high until both entries are taken. csr_write_data sets the
// step (source rate over target rate, reset value 1.0); steps below 1/64 are
// raised to 1/64. Write it only while the block is idle.
// ============================================================================
`default_nettype none

module linear_interp_resampler (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] req_sample_in,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [lir_pkg::SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                                        rsp_last_of_run,
   input  wire logic                                   csr_write_enable,
   input  wire logic [lir_pkg::STEP_BITS-1:0]          csr_write_data
);
   import lir_pkg::*;

   logic [STEP_BITS-1:0] rate_step_ff, rate_step_in;
   logic                 push_valid, push_ready;
   job_type              push_job;
   logic                 job_valid, job_pop;
   job_type              job;

   // Step register
   always_comb begin
      rate_step_in = csr_write_enable ? csr_write_data : rate_step_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_step_ff <= STEP_RESET;
      end else begin
         rate_step_ff <= rate_step_in;
      end
   end

   lir_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_sample_in (req_sample_in),
      .rate_step     (rate_step_ff),
      .push_valid    (push_valid),
      .push_ready    (push_ready),
      .push_job      (push_job)
   );

   lir_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (job_valid),
      .pop_ready  (job_pop),
      .pop_job    (job)
   );

   lir_back u_back (
      .clock           (clock),
      .reset           (reset),
      .job_valid       (job_valid),
      .job_pop         (job_pop),
      .job             (job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

`default_nettype wire

// ===== hdl/lir_front.sv =====
// ============================================================================
// lir_front
// Input front end: accepts source samples, tracks the previous sample and
// builds the job record (previous sample, difference, bounded step).
// ============================================================================
`default_nettype none

module lir_front (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic [lir_pkg::STEP_BITS-1:0]      rate_step,
   output logic                                    push_valid,
   input  wire logic                               push_ready,
   output lir_pkg::job_type                        push_job
);
   import lir_pkg::*;

   logic signed [SAMPLE_BITS-1:0] prior_sample_ff, prior_sample_in;
   logic                          prior_valid_ff, prior_valid_in;
   logic signed [SAMPLE_BITS-1:0] prev;
   logic                          accept;

   // Take a sample whenever the queue has room
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && push_ready;

   // Build the job: first sample stands in for its own predecessor
   always_comb begin
      prev          = prior_valid_ff ? prior_sample_ff : req_sample_in;
      push_job.prev = prev;
      push_job.diff = DIFF_BITS'(req_sample_in) - DIFF_BITS'(prev);
      push_job.step = (rate_step < STEP_MIN_CODE) ? STEP_MIN_CODE : rate_step;
   end

   // Hold the latest sample as the next predecessor
   always_comb begin
      prior_sample_in = prior_sample_ff;
      prior_valid_in  = prior_valid_ff;
      if (accept) begin
         prior_sample_in = req_sample_in;
         prior_valid_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prior_sample_ff <= '0;
         prior_valid_ff  <= 1'b0;
      end else begin
         prior_sample_ff <= prior_sample_in;
         prior_valid_ff  <= prior_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lir_queue.sv =====
// ============================================================================
// lir_queue
// Small job FIFO that decouples the front end from the interpolation engine.
// ============================================================================
`default_nettype none

module lir_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   output logic                  push_ready,
   input  wire lir_pkg::job_type push_job,
   output logic                  pop_valid,
   input  wire logic             pop_ready,
   output lir_pkg::job_type      pop_job
);
   import lir_pkg::*;

   job_type               entries_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0]  count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != QCNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers with wrap at the queue depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the job payload
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/lir_back.sv =====
// ============================================================================
// lir_back
// Interpolation engine: walks the read position across each job, one result
// per cycle unless stalled, through a multiply stage and an output register.
// ============================================================================
`default_nettype none

module lir_back (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   job_valid,
   output logic                                        job_pop,
   input  wire lir_pkg::job_type                       job,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic signed [lir_pkg::SAMPLE_BITS-1:0]      rsp_sample_out,
   output logic                                        rsp_last_of_run
);
   import lir_pkg::*;

   // Position clamped to no lower than -1.0 after dropping by 1.0
   function automatic logic signed [POS_BITS-1:0] drop_one(
      input logic signed [POS_BITS:0] value
   );
      logic signed [POS_BITS:0] lowered;
      lowered = value - POS_ONE_EXT;
      if (lowered < -POS_ONE_EXT) begin
         lowered = -POS_ONE_EXT;
      end
      return lowered[POS_BITS-1:0];
   endfunction

   logic signed [POS_BITS-1:0]    pos_ff, pos_in;
   logic [RUN_BITS-1:0]           run_ff, run_in;

   logic                          p_valid_ff, p_valid_in;
   logic signed [DIFF_BITS-1:0]   p_scaled_ff, p_scaled_in;
   logic signed [SAMPLE_BITS-1:0] p_prev_ff, p_prev_in;
   logic                          p_last_ff, p_last_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_ff, rsp_sample_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          rsp_advance, p_advance, emit, last;
   logic signed [POS_BITS:0]      pos_ext, step_ext, sum_ext;
   logic [FRAC_BITS-1:0]          frac;
   logic signed [PROD_BITS-1:0]   product;
   logic signed [PROD_BITS-1:0]   product_shr;
   logic signed [DIFF_BITS-1:0]   out_sum;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_last_of_run = rsp_last_ff;

   assign rsp_advance = !rsp_valid_ff || rsp_ready;
   assign p_advance   = !p_valid_ff || rsp_advance;

   // Fraction between prev and x is pos + 1.0, the low bits of pos
   always_comb begin
      pos_ext     = {pos_ff[POS_BITS-1], pos_ff};
      step_ext    = $signed({{(POS_BITS + 1 - STEP_BITS){1'b0}}, job.step});
      sum_ext     = pos_ext + step_ext;
      frac        = pos_ff[FRAC_BITS-1:0];
      product     = $signed({1'b0, frac}) * job.diff;
      product_shr = product >>> FRAC_BITS;
   end

   // Sequence the run: emit while position is negative, retire on the last result, or at once when there is none
   always_comb begin
      pos_in      = pos_ff;
      run_in      = run_ff;
      job_pop     = 1'b0;
      emit        = 1'b0;
      last        = !sum_ext[POS_BITS] || (run_ff == RUN_BITS'(MAX_RUN - 1));
      if (job_valid) begin
         if (pos_ff[POS_BITS-1]) begin
            if (p_advance) begin
               emit = 1'b1;
               if (last) begin
                  job_pop = 1'b1;
                  pos_in  = drop_one(sum_ext);
                  run_in  = '0;
               end else begin
                  pos_in  = sum_ext[POS_BITS-1:0];
                  run_in  = run_ff + 1'b1;
               end
            end
         end else begin
            job_pop = 1'b1;
            pos_in  = drop_one(pos_ext);
            run_in  = '0;
         end
      end
   end

   // Product stage: hold while the output register is stalled
   always_comb begin
      p_valid_in  = p_valid_ff;
      p_scaled_in = p_scaled_ff;
      p_prev_in   = p_prev_ff;
      p_last_in   = p_last_ff;
      if (p_advance) begin
         p_valid_in  = emit;
         p_scaled_in = product_shr[DIFF_BITS-1:0];
         p_prev_in   = job.prev;
         p_last_in   = last;
      end
   end

   // Output register: add the scaled difference to the previous sample
   always_comb begin
      out_sum       = DIFF_BITS'(p_prev_ff) + p_scaled_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_sample_in = rsp_sample_ff;
      rsp_last_in   = rsp_last_ff;
      if (rsp_advance) begin
         rsp_valid_in  = p_valid_ff;
         rsp_sample_in = out_sum[SAMPLE_BITS-1:0];
         rsp_last_in   = p_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         run_ff       <= '0;
         p_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         run_ff       <= run_in;
         p_valid_ff   <= p_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_scaled_ff   <= p_scaled_in;
      p_prev_ff     <= p_prev_in;
      p_last_ff     <= p_last_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

// ===== hdl/lir_checker.sv =====
// ============================================================================
// lir_checker
// Port-level checks on the resampler, bound to the top level.
// ============================================================================
`default_nettype none

module lir_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   req_valid,
   input wire logic                                   req_ready,
   input wire logic signed [lir_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input wire logic                                   rsp_valid,
   input wire logic                                   rsp_ready,
   input wire logic signed [lir_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input wire logic                                   rsp_last_of_run,
   input wire logic                                   csr_write_enable,
   input wire logic [lir_pkg::STEP_BITS-1:0]          csr_write_data
);
   import lir_pkg::*;

   logic [1:0] seen_ff, seen_in;
   logic       req_fire;

   assign req_fire = req_valid && req_ready;

   // Count accepted transactions since reset, saturating at two
   always_comb begin
      seen_in = seen_ff;
      if (req_fire && (seen_ff != 2'd2)) begin
         seen_in = seen_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= '0;
      end else begin
         seen_ff <= seen_in;
      end
   end

   // A stalled result holds its payload
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample_out)
                                  && $stable(rsp_last_of_run))
      else $error("result changed while stalled");

   // A waiting request holds its sample
   a_req_hold : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_sample_in))
      else $error("request changed while waiting");

   // Reset empties the output side
   a_reset_idle : assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The first sample only primes the position, so results need two inputs
   a_needs_two : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (seen_ff == 2'd2))
      else $error("result before second input");

   // Step writes land only while the output side is idle, with known data
   a_csr_idle : assert property (@(posedge clock) disable iff (reset)
      csr_write_enable |-> !rsp_valid && !$isunknown(csr_write_data))
      else $error("step written while results pending");

endmodule

bind linear_interp_resampler lir_checker u_lir_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_sample_in    (req_sample_in),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sample_out   (rsp_sample_out),
   .rsp_last_of_run  (rsp_last_of_run),
   .csr_write_enable (csr_write_enable),
   .csr_write_data   (csr_write_data)
);

`default_nettype wire

// ===== bench/linear_interp_resampler_checker.sv =====
// ============================================================================
// linear_interp_resampler_checker
// Watches the request, response and CSR ports of the resampler, predicts the
// interpolated output stream and compares every response against it.
// ============================================================================

module linear_interp_resampler_checker (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   input  wire logic                                   req_ready,
   input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] req_sample_in,
   input  wire logic                                   rsp_valid,
   input  wire logic                                   rsp_ready,
   input  wire logic signed [lir_pkg::SAMPLE_BITS-1:0] rsp_sample_out,
   input  wire logic                                   rsp_last_of_run,
   input  wire logic                                   csr_write_enable,
   input  wire logic [lir_pkg::STEP_BITS-1:0]          csr_write_data,
   output int                                          failures,
   output int                                          outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import lir_pkg::*;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample;
      logic                          last;
   } interp_sample_type;

   // Shadow of the block's state and its step register
   logic [STEP_BITS-1:0]          step_shadow;
   logic signed [SAMPLE_BITS-1:0] held_sample;
   logic                          held_valid;
   longint                        phase_pos;

   interp_sample_type expected_samples[$];
   int fail_tally;

   // Count a failure; print only the first few
   task automatic log_failure(input string msg);
      fail_tally++;
      if (fail_tally <= 10) begin
         $display("%0t ns: %s", $time, msg);
      end
   endtask

   // Queue the run of outputs one source sample causes, then advance the position
   task automatic interpolate_run(input logic signed [SAMPLE_BITS-1:0] x);
      longint cur;
      longint base;
      longint step;
      longint frac;
      longint prod;
      int count;
      interp_sample_type item;
      cur = longint'(x);
      base = held_valid ? longint'(held_sample) : cur;
      step = longint'(step_shadow);
      count = 0;
      if (step < STEP_MIN) begin
         step = STEP_MIN;
      end
      while (phase_pos < 0 && count < MAX_RUN) begin
         frac = phase_pos + POS_ONE;
         if (frac < 0) begin
            frac = 0;
         end
         // Arithmetic shift floors the product toward minus infinity
         prod = frac * (cur - base);
         item.sample = SAMPLE_BITS'(base + (prod >>> FRAC_BITS));
         item.last = 1'b0;
         expected_samples = {expected_samples, item};
         count++;
         phase_pos += step;
      end
      if (count > 0) begin
         expected_samples[expected_samples.size()-1].last = 1'b1;
      end
      phase_pos -= POS_ONE;
      if (phase_pos < -POS_ONE) begin
         phase_pos = -POS_ONE;
      end
      held_sample = x;
      held_valid = 1'b1;
   endtask

   // Track CSR writes, predict on each request, compare each response
   always @(posedge clock) begin
      interp_sample_type want;
      if (reset) begin
         step_shadow = STEP_RESET;
         held_sample = '0;
         held_valid  = 1'b0;
         phase_pos   = 0;
         expected_samples.delete();
      end else begin
         if (csr_write_enable) begin
            step_shadow = csr_write_data;
         end
         if (req_valid && req_ready) begin
            interpolate_run(req_sample_in);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_samples.size() == 0) begin
               log_failure($sformatf("unexpected response sample_out=%0d last_of_run=%0b",
                                     rsp_sample_out, rsp_last_of_run));
            end else begin
               want = expected_samples.pop_front();
               if (rsp_sample_out !== want.sample || rsp_last_of_run !== want.last) begin
                  log_failure($sformatf(
                     "mismatch: expected sample_out=%0d last_of_run=%0b, got %0d %0b",
                     want.sample, want.last, rsp_sample_out, rsp_last_of_run));
               end
            end
         end
      end
      failures    <= fail_tally;
      outstanding <= expected_samples.size();
   end

endmodule

// ===== bench/linear_interp_resampler_tb.sv =====
// ============================================================================
// linear_interp_resampler_tb
// Drives source samples and rate steps into the resampler under several
// idle and stall patterns; a side checker predicts and compares the output.
// ============================================================================

module linear_interp_resampler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lir_pkg::*;

   localparam int DRAIN_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 24;
   localparam int BATCHES       = 8;
   localparam int BATCH_ITEMS   = 24;
   localparam int SPARSE_ITEMS  = 24;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic signed [SAMPLE_BITS-1:0] req_sample_in = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_sample_out;
   logic                          rsp_last_of_run;
   logic                          csr_write_enable = 1'b0;
   logic [STEP_BITS-1:0]          csr_write_data = '0;

   int failures;
   int outstanding;
   int idle_pct  = 0;
   int stall_pct = 0;
   logic signed [SAMPLE_BITS-1:0] last_sent = '0;

   linear_interp_resampler uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data)
   );

   linear_interp_resampler_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_sample_in   (req_sample_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_sample_out  (rsp_sample_out),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .failures        (failures),
      .outstanding     (outstanding)
   );

   always #4 clock = ~clock;

   // Stall the response side at random
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Hard stop in case the run hangs
   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

   // Set the idling pattern: none, sender idle, receiver stall, both
   task automatic set_idling(input int mode);
      case (mode)
         0: begin idle_pct = 0;  stall_pct = 0;  end
         1: begin idle_pct = 48; stall_pct = 0;  end
         2: begin idle_pct = 0;  stall_pct = 48; end
         default: begin idle_pct = 20; stall_pct = 20; end
      endcase
   endtask

   // Offer one sample, idling first at random, and hold it until accepted
   task automatic send_sample(input logic signed [SAMPLE_BITS-1:0] x);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) begin
         gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample_in <= x;
      do @(posedge clock); while (!req_ready);
      last_sent = x;
   endtask

   // Wait until every predicted output has come back, then let the engine settle
   task automatic wait_drained();
      int guard;
      guard = 0;
      do begin
         @(posedge clock);
         guard++;
      end while (outstanding != 0 && guard < DRAIN_LIMIT);
      if (outstanding != 0) begin
         $display("tb: failure");
         $finish;
      end else begin
         repeat (SETTLE_CYCLES) @(posedge clock);
      end
   endtask

   // Drop valid, drain, then write the step register
   task automatic write_step(input logic [STEP_BITS-1:0] value);
      req_valid <= 1'b0;
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Mostly full-range samples, with rails and small moves mixed in
   function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
      case ($urandom_range(9))
         0: pick_sample = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         1: pick_sample = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
         2: pick_sample = last_sent + SAMPLE_BITS'($urandom_range(511)) - SAMPLE_BITS'(256);
         default: pick_sample = SAMPLE_BITS'($urandom);
      endcase
   endfunction

   function automatic logic [STEP_BITS-1:0] pick_step();
      case ($urandom_range(7))
         0: pick_step = STEP_BITS'($urandom_range(int'(STEP_MIN) - 1));
         1: pick_step = STEP_MIN_CODE;
         2: pick_step = STEP_BITS'($urandom_range(int'(STEP_MIN), 1 << FRAC_BITS));
         3: pick_step = STEP_RESET;
         default: pick_step = STEP_BITS'($urandom_range(int'(STEP_MIN), 1 << 26));
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset step of 1.0, first sample with no history, rails
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      send_sample(24'sd0);
      send_sample(-24'sd1);

      // Zero and just-below-minimum steps get clamped to the 64-output run
      write_step('0);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      write_step(STEP_MIN_CODE - 1);
      send_sample(24'sd1);
      send_sample(-24'sd1);

      // Lowest legal step, then decimating and upsampling ratios
      write_step(STEP_MIN_CODE);
      send_sample(24'sd100);
      send_sample(-24'sd100);
      write_step(32'h0180_0000);
      send_sample(24'sd8388607);
      send_sample(24'sd8388607);
      send_sample(-24'sd8388608);
      write_step(32'h0055_5555);
      send_sample(-24'sd8388608);
      send_sample(24'sd8388607);
      send_sample(24'sd12345);

      // Random batches, each with its own step and idling pattern
      for (int b = 0; b < BATCHES; b++) begin
         write_step(pick_step());
         set_idling(b % 4);
         for (int i = 0; i < BATCH_ITEMS; i++) begin
            send_sample(pick_sample());
         end
      end

      // Largest step: outputs only about once every 256 inputs
      write_step('1);
      set_idling(3);
      for (int i = 0; i < SPARSE_ITEMS; i++) begin
         send_sample(pick_sample());
      end
      req_valid <= 1'b0;
      wait_drained();

      if (failures == 0 && outstanding == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/lir_pkg.sv
hdl/lir_front.sv
hdl/lir_queue.sv
hdl/lir_back.sv
hdl/linear_interp_resampler.sv
hdl/lir_checker.sv
bench/linear_interp_resampler_checker.sv
bench/linear_interp_resampler_tb.sv
